### hw/rtl/rrca_pkg.sv
package rrca_pkg;

  localparam int MAX_TERMS_DEF = 16;

  localparam int DVD_W  = 26;
  localparam int DSR_W  = 47;
  localparam int VAL_W  = 23;
  localparam int PROD_W = 2 * VAL_W;

  localparam int SCALE_NUM  = 1000000;
  localparam int NUM_LIMIT  = 1023;
  localparam int DEN_LIMIT  = 2047;
  localparam int EXACT_DEN  = 168;
  localparam int NORM_LIMIT = 512;
  localparam int EXP_BASE   = 10;

  typedef struct packed {
    logic [9:0]  phase_cycle;
    logic [15:0] target_rate;
  } req_t;

  typedef struct packed {
    logic [19:0] whole_ratio;
    logic [31:0] frac_numerator;
    logic [31:0] frac_denominator;
    logic [22:0] inverse_mantissa;
    logic [3:0]  inverse_exponent;
    logic        error_flag;
  } res_t;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DSR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] quot;
    logic [DVD_W-1:0] rem;
  } div_rsp_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DEN,
    W_DEN,
    S_WHOLE,
    W_WHOLE,
    S_EU,
    W_EU,
    S_N,
    W_N,
    S_D,
    W_D,
    S_CHK,
    S_RB_MUL,
    S_RB_ADD,
    S_NORM,
    W_MANT
  } state_t;

endpackage

### hw/rtl/rrca_div.sv
module rrca_div (
  input  logic               clk,
  input  logic               rst,
  input  rrca_pkg::div_req_t req,
  output rrca_pkg::div_rsp_t rsp
);

  localparam int CNT_W = $clog2(rrca_pkg::DVD_W + 1);

  logic                       busy;
  logic                       done;
  logic [CNT_W-1:0]           cnt;
  logic [rrca_pkg::DVD_W-1:0] dvd;
  logic [rrca_pkg::DVD_W-1:0] rem;
  logic [rrca_pkg::DSR_W-1:0] dsr;
  logic [rrca_pkg::DVD_W:0]   trial;
  logic                       sub_ok;
  logic [rrca_pkg::DVD_W-1:0] rem_next;

  always_comb begin
    trial    = {rem, dvd[rrca_pkg::DVD_W-1]};
    sub_ok   = rrca_pkg::DSR_W'(trial) >= dsr;
    rem_next = sub_ok ? rrca_pkg::DVD_W'(trial - (rrca_pkg::DVD_W + 1)'(dsr))
                      : rrca_pkg::DVD_W'(trial);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(rrca_pkg::DVD_W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd <= req.dividend;
      rem <= '0;
      dsr <= req.divisor;
    end else if (busy) begin
      rem <= rem_next;
      dvd <= {dvd[rrca_pkg::DVD_W-2:0], sub_ok};
    end
  end

  assign rsp.done = done;
  assign rsp.quot = dvd;
  assign rsp.rem  = rem;

endmodule

### hw/rtl/rrca_norm.sv
module rrca_norm (
  input  logic [rrca_pkg::DSR_W-1:0] num,
  input  logic [rrca_pkg::DSR_W-1:0] den,
  output logic [31:0]                num_o,
  output logic [rrca_pkg::DSR_W-1:0] den_o,
  output logic [3:0]                 ex
);

  logic [3:0]  s;
  logic [17:0] d_sh;

  always_comb begin
    s     = 4'd8;
    d_sh  = '0;
    num_o = num[31:0];
    den_o = den;
    ex    = 4'd12;
    if (den <= rrca_pkg::DSR_W'(rrca_pkg::NORM_LIMIT)) begin
      for (int j = 7; j >= 0; j--) begin
        d_sh = 18'(den[9:0]) << (j + 1);
        if (d_sh > 18'(rrca_pkg::NORM_LIMIT)) begin
          s = 4'(j);
        end
      end
      num_o = num[31:0] << s;
      den_o = den << s;
      ex    = 4'd9;
    end else if (den <= rrca_pkg::DSR_W'(1024)) begin
      ex = 4'd10;
    end else if (den <= rrca_pkg::DSR_W'(2048)) begin
      ex = 4'd11;
    end
  end

endmodule

### hw/rtl/resample_ratio_cfrac_approx.sv
// Resample ratio calculator. A request carries phase_cycle and target_rate;
// one result follows with the whole ratio, the reduced fraction after
// continued-fraction reduction, and the inverse mantissa and exponent.
// Both channels use valid and ready. The block takes one request at a time:
// req_ready is high only while the sequencer is idle and no finished result
// is waiting to enter the output register.
// All divisions run on one shared restoring divider, one quotient bit per
// cycle. A request needs 3 divisions on the exact path, up to MAX_TERMS + 5
// divisions otherwise, plus a multiply state and an add state per rebuild step.
// A request whose product is below ten ends after one division with the
// error flag set and all other fields zero.
// The result sits in an output register until res_ready takes it; a stalled
// receiver holds the finished result and the next request may already run,
// but it completes only once the register is free.
// Reset is synchronous and clears the sequencer and res_valid; no state is
// kept between requests.
module resample_ratio_cfrac_approx #(
  parameter int MAX_TERMS = rrca_pkg::MAX_TERMS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  rrca_pkg::req_t req,
  output logic           res_valid,
  input  logic           res_ready,
  output rrca_pkg::res_t res
);

  localparam int CW = $clog2(MAX_TERMS + 1);
  localparam int TW = $clog2(MAX_TERMS);
  localparam int VW = rrca_pkg::VAL_W;
  localparam int DW = rrca_pkg::DSR_W;

  rrca_pkg::state_t   state, state_next;
  rrca_pkg::div_req_t div_req;
  rrca_pkg::div_rsp_t div_rsp;
  rrca_pkg::res_t     res_next;

  logic [9:0]               p;
  logic [15:0]              r;
  logic [VW-1:0]            den;
  logic [19:0]              whole;
  logic [VW-1:0]            frem;
  logic [VW-1:0]            a;
  logic [VW-1:0]            b;
  logic [CW-1:0]            i;
  logic [CW-1:0]            k;
  logic                     zbrk;
  logic [DW-1:0]            n;
  logic [DW-1:0]            d;
  logic [rrca_pkg::PROD_W-1:0] prod;
  logic [DW-1:0]            t;
  logic [TW-1:0]            j;
  logic [3:0]               ex;
  logic [31:0]              nout;
  logic [22:0]              mant;
  logic                     err;
  logic [VW-1:0]            q [MAX_TERMS];
  logic                     swap;
  logic [31:0]              norm_n;
  logic [DW-1:0]            norm_d;
  logic [3:0]               norm_ex;
  logic                     fin;
  logic                     fin_err;
  logic                     pend;

  rrca_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  rrca_norm u_norm (
    .num   (n),
    .den   (d),
    .num_o (norm_n),
    .den_o (norm_d),
    .ex    (norm_ex)
  );

  assign swap      = b <= a;
  assign t         = DW'(prod) + n;
  assign req_ready = state == rrca_pkg::S_IDLE && !pend;

  always_comb begin
    state_next       = state;
    div_req.start    = 1'b0;
    div_req.dividend = '0;
    div_req.divisor  = '0;
    unique case (state)
      rrca_pkg::S_IDLE: begin
        if (req_valid) begin
          state_next = rrca_pkg::S_DEN;
        end
      end
      rrca_pkg::S_DEN: begin
        div_req.start    = 1'b1;
        div_req.dividend = rrca_pkg::DVD_W'(p * r);
        div_req.divisor  = DW'(10);
        state_next       = rrca_pkg::W_DEN;
      end
      rrca_pkg::W_DEN: begin
        if (div_rsp.done) begin
          state_next = (div_rsp.quot == '0) ? rrca_pkg::S_IDLE : rrca_pkg::S_WHOLE;
        end
      end
      rrca_pkg::S_WHOLE: begin
        div_req.start    = 1'b1;
        div_req.dividend = rrca_pkg::DVD_W'(rrca_pkg::SCALE_NUM);
        div_req.divisor  = DW'(den);
        state_next       = rrca_pkg::W_WHOLE;
      end
      rrca_pkg::W_WHOLE: begin
        if (div_rsp.done) begin
          state_next = (div_rsp.rem == '0) ? rrca_pkg::S_NORM : rrca_pkg::S_EU;
        end
      end
      rrca_pkg::S_EU: begin
        if (i == CW'(MAX_TERMS) || b == '0) begin
          state_next = rrca_pkg::S_N;
        end else begin
          div_req.start    = 1'b1;
          div_req.dividend = rrca_pkg::DVD_W'(swap ? a : b);
          div_req.divisor  = DW'(swap ? b : a);
          state_next       = rrca_pkg::W_EU;
        end
      end
      rrca_pkg::W_EU: begin
        if (div_rsp.done) begin
          state_next = rrca_pkg::S_EU;
        end
      end
      rrca_pkg::S_N: begin
        div_req.start    = 1'b1;
        div_req.dividend = rrca_pkg::DVD_W'(frem);
        div_req.divisor  = DW'(a);
        state_next       = rrca_pkg::W_N;
      end
      rrca_pkg::W_N: begin
        if (div_rsp.done) begin
          state_next = rrca_pkg::S_D;
        end
      end
      rrca_pkg::S_D: begin
        div_req.start    = 1'b1;
        div_req.dividend = rrca_pkg::DVD_W'(den);
        div_req.divisor  = DW'(a);
        state_next       = rrca_pkg::W_D;
      end
      rrca_pkg::W_D: begin
        if (div_rsp.done) begin
          state_next = rrca_pkg::S_CHK;
        end
      end
      rrca_pkg::S_CHK: begin
        if (n > DW'(rrca_pkg::NUM_LIMIT) || d > DW'(rrca_pkg::DEN_LIMIT)) begin
          state_next = rrca_pkg::S_RB_MUL;
        end else begin
          state_next = rrca_pkg::S_NORM;
        end
      end
      rrca_pkg::S_RB_MUL: begin
        state_next = rrca_pkg::S_RB_ADD;
      end
      rrca_pkg::S_RB_ADD: begin
        if (d > DW'(rrca_pkg::NUM_LIMIT) || t > DW'(rrca_pkg::DEN_LIMIT) || j == '0) begin
          state_next = rrca_pkg::S_NORM;
        end else begin
          state_next = rrca_pkg::S_RB_MUL;
        end
      end
      rrca_pkg::S_NORM: begin
        if (d == '0) begin
          state_next = rrca_pkg::S_IDLE;
        end else begin
          div_req.start    = 1'b1;
          div_req.dividend = rrca_pkg::DVD_W'(1) << (5'(norm_ex) + 5'(rrca_pkg::EXP_BASE));
          div_req.divisor  = norm_d;
          state_next       = rrca_pkg::W_MANT;
        end
      end
      rrca_pkg::W_MANT: begin
        if (div_rsp.done) begin
          state_next = rrca_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = rrca_pkg::S_IDLE;
      end
    endcase
  end

  // The finished result, error results included, lands in the output register; if the
  // register is still full, the sequencer waits in idle with the result held.
  always_comb begin
    fin_err = (state == rrca_pkg::W_DEN && div_rsp.done && div_rsp.quot == '0)
           || (state == rrca_pkg::S_NORM && d == '0);
    fin     = fin_err || (state == rrca_pkg::W_MANT && div_rsp.done);
    res_next = '0;
    res_next.error_flag = err;
    if (!err) begin
      res_next.whole_ratio      = whole;
      res_next.frac_numerator   = nout;
      res_next.frac_denominator = d[31:0];
      res_next.inverse_mantissa = mant;
      res_next.inverse_exponent = ex;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= rrca_pkg::S_IDLE;
      pend      <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (pend && (!res_valid || res_ready)) begin
        res_valid <= 1'b1;
        pend      <= 1'b0;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
      if (fin) begin
        pend <= 1'b1;
      end
      if (state == rrca_pkg::S_IDLE && pend) begin
        state <= rrca_pkg::S_IDLE;
      end else begin
        state <= state_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pend && (!res_valid || res_ready)) begin
      res <= res_next;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      rrca_pkg::S_IDLE: begin
        if (req_valid && !pend) begin
          p   <= req.phase_cycle;
          r   <= req.target_rate;
          err <= 1'b0;
        end
      end
      rrca_pkg::W_DEN: begin
        if (div_rsp.done) begin
          den <= VW'(div_rsp.quot);
          if (div_rsp.quot == '0) begin
            err <= 1'b1;
          end
        end
      end
      rrca_pkg::W_WHOLE: begin
        if (div_rsp.done) begin
          whole <= div_rsp.quot[19:0];
          frem  <= VW'(div_rsp.rem);
          a     <= VW'(div_rsp.rem);
          b     <= den;
          i     <= '0;
          n     <= '0;
          d     <= DW'(rrca_pkg::EXACT_DEN);
        end
      end
      rrca_pkg::S_EU: begin
        if (i == CW'(MAX_TERMS)) begin
          k    <= CW'(MAX_TERMS);
          zbrk <= 1'b0;
        end else if (b == '0) begin
          k    <= i + CW'(1);
          zbrk <= 1'b1;
        end else if (swap) begin
          a <= b;
        end
      end
      rrca_pkg::W_EU: begin
        if (div_rsp.done) begin
          q[i[TW-1:0]] <= VW'(div_rsp.quot);
          b            <= VW'(div_rsp.rem);
          i            <= i + CW'(1);
        end
      end
      rrca_pkg::W_N: begin
        if (div_rsp.done) begin
          n <= DW'(div_rsp.quot);
        end
      end
      rrca_pkg::W_D: begin
        if (div_rsp.done) begin
          d <= DW'(div_rsp.quot);
        end
      end
      rrca_pkg::S_CHK: begin
        if (n > DW'(rrca_pkg::NUM_LIMIT) || d > DW'(rrca_pkg::DEN_LIMIT)) begin
          n <= DW'(1);
          d <= zbrk ? '0 : DW'(q[TW'(k - CW'(1))]);
          j <= TW'(k - CW'(2));
        end
      end
      rrca_pkg::S_RB_MUL: begin
        prod <= d[VW-1:0] * q[j];
      end
      rrca_pkg::S_RB_ADD: begin
        n <= d;
        d <= t;
        j <= j - TW'(1);
      end
      rrca_pkg::S_NORM: begin
        if (d == '0) begin
          err <= 1'b1;
        end else begin
          nout <= norm_n;
          d    <= norm_d;
          ex   <= norm_ex;
        end
      end
      rrca_pkg::W_MANT: begin
        if (div_rsp.done) begin
          mant <= div_rsp.quot[22:0];
        end
      end
      default: begin
      end
    endcase
  end

`ifndef ASSERT_OFF
  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == rrca_pkg::W_DEN || state == rrca_pkg::W_WHOLE
      || state == rrca_pkg::W_EU || state == rrca_pkg::W_N || state == rrca_pkg::W_D
      || state == rrca_pkg::W_MANT))
    else $error("divider finished outside a wait step");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.error_flag |-> res.whole_ratio == '0 && res.inverse_exponent == '0)
    else $error("error result carries nonzero fields");

  a_exp_range: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res.error_flag |->
      res.inverse_exponent >= 4'd9 && res.inverse_exponent <= 4'd12)
    else $error("exponent out of range");

  a_term_bound: assert property (@(posedge clk) disable iff (rst)
    state == rrca_pkg::W_EU |-> i < CW'(MAX_TERMS))
    else $error("term counter overran the quotient store");
`endif

endmodule

### verif/tb_resample_ratio_cfrac_approx.sv
`timescale 1ns / 1ps

module tb_resample_ratio_cfrac_approx;

  localparam int TERMS = rrca_pkg::MAX_TERMS_DEF;

  class ratio_scoreboard;
    rrca_pkg::res_t pending[$];
    int   mismatches;
    int   checked;
    int   exact_seen;
    int   error_seen;

    function rrca_pkg::res_t compute(rrca_pkg::req_t rq);
      rrca_pkg::res_t o;
      longint unsigned p, r, den, whole, rem, n, d, a, b, t, ex;
      longint unsigned q[TERMS];
      int k, i;
      int unsigned s;
      o = '0;
      p = rq.phase_cycle;
      r = rq.target_rate;
      den = (p * r * 100) / 1000;
      if (den == 0) begin
        o.error_flag = 1'b1;
        return o;
      end
      whole = 1000000 / den;
      rem = 1000000 - whole * den;
      if (rem == 0) begin
        n = 0;
        d = 168;
      end else begin
        for (i = 0; i < TERMS; i++) q[i] = 0;
        a = rem;
        b = den;
        k = 0;
        for (i = 0; i < TERMS; i++) begin
          k++;
          if (b == 0) break;
          if (b <= a) begin
            t = b;
            b = a;
            a = t;
          end
          q[i] = b / a;
          b = b % a;
        end
        n = rem / a;
        d = den / a;
        if (n > 1023 || d > 2047) begin
          n = 1;
          d = q[k-1];
          for (i = k - 2; i >= 0; i--) begin
            t = d * q[i] + n;
            n = d;
            d = t;
            if (n > 1023 || d > 2047) break;
          end
        end
      end
      if (d <= 512) begin
        s = 0;
        while (s < 8 && (d << (s + 1)) <= 512) s++;
        n = n << s;
        d = d << s;
        ex = 9;
      end else if (d <= 1024) ex = 10;
      else if (d <= 2048) ex = 11;
      else ex = 12;
      if (d == 0) begin
        o.error_flag = 1'b1;
        return o;
      end
      o.whole_ratio = whole[19:0];
      o.frac_numerator = n[31:0];
      o.frac_denominator = d[31:0];
      o.inverse_mantissa = 23'((64'd1 << (ex + 10)) / d);
      o.inverse_exponent = ex[3:0];
      return o;
    endfunction

    function void note_request(rrca_pkg::req_t rq);
      rrca_pkg::res_t e;
      e = compute(rq);
      if (e.error_flag) error_seen++;
      else if (e.frac_numerator == 0) exact_seen++;
      pending.push_back(e);
    endfunction

    function void check_result(rrca_pkg::res_t got);
      rrca_pkg::res_t e;
      if (pending.size() == 0) begin
        $error("unexpected result %h", got);
        mismatches++;
        return;
      end
      e = pending.pop_front();
      checked++;
      if (got.whole_ratio !== e.whole_ratio) begin
        $error("whole_ratio exp %0d got %0d", e.whole_ratio, got.whole_ratio);
        mismatches++;
      end
      if (got.frac_numerator !== e.frac_numerator) begin
        $error("frac_numerator exp %0d got %0d", e.frac_numerator, got.frac_numerator);
        mismatches++;
      end
      if (got.frac_denominator !== e.frac_denominator) begin
        $error("frac_denominator exp %0d got %0d", e.frac_denominator,
               got.frac_denominator);
        mismatches++;
      end
      if (got.inverse_mantissa !== e.inverse_mantissa) begin
        $error("inverse_mantissa exp %0d got %0d", e.inverse_mantissa,
               got.inverse_mantissa);
        mismatches++;
      end
      if (got.inverse_exponent !== e.inverse_exponent) begin
        $error("inverse_exponent exp %0d got %0d", e.inverse_exponent,
               got.inverse_exponent);
        mismatches++;
      end
      if (got.error_flag !== e.error_flag) begin
        $error("error_flag exp %0d got %0d", e.error_flag, got.error_flag);
        mismatches++;
      end
    endfunction
  endclass

  logic clk, rst;
  logic req_valid, req_ready, res_valid, res_ready;
  rrca_pkg::req_t req;
  rrca_pkg::res_t res;
  ratio_scoreboard board;
  int send_idle_pct, recv_stall_pct;
  bit long_hold;
  int requests_sent;

  resample_ratio_cfrac_approx dut (
    .clk(clk), .rst(rst), .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .res_valid(res_valid), .res_ready(res_ready), .res(res)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #80ms;
    $display("tb_resample_ratio_cfrac_approx: FAIL");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && res_valid && res_ready) board.check_result(res);
  end

  initial begin : receiver
    int hold;
    res_ready <= 1'b0;
    @(posedge clk);
    forever begin
      @(posedge clk);
      if (long_hold) begin
        res_ready <= 1'b0;
        for (hold = 0; hold < 3000; hold++) @(posedge clk);
        long_hold = 0;
      end
      res_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic send(input logic [9:0] pc, input logic [15:0] tr);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req.phase_cycle <= pc;
    req.target_rate <= tr;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    board.note_request('{phase_cycle: pc, target_rate: tr});
    requests_sent++;
  endtask

  task automatic send_random();
    int sel;
    sel = $urandom_range(9);
    if (sel == 0) send(10'($urandom_range(1023)), 16'($urandom_range(65535)));
    else if (sel < 4) send(10'($urandom_range(1, 40)), 16'($urandom_range(1, 500)));
    else if (sel == 4) send(10'($urandom_range(1, 1023)), 16'($urandom_range(1, 30)));
    else send(10'($urandom_range(1, 1023)), 16'($urandom_range(1, 65535)));
  endtask

  initial begin
    int i, phase, waited;
    board = new();
    req_valid <= 1'b0;
    req <= '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    long_hold = 0;
    rst <= 1'b1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send(0, 0);
    send(0, 65535);
    send(1023, 0);
    send(1, 1);
    send(1, 9);
    send(1, 10);
    send(1, 65535);
    send(1023, 65535);
    send(1023, 1);
    send(10, 100);
    send(100, 1000);
    send(5, 32);
    send(1, 123);
    send(7, 13);
    send(3, 11);
    send(512, 341);
    send(1, 16);
    send(10'h2AA, 16'h5555);
    send(10'h155, 16'hAAAA);
    send(1, 2);
    long_hold = 1;
    for (i = 0; i < 10; i++) send_random();
    for (phase = 0; phase < 4; phase++) begin
      send_idle_pct = (phase == 1 || phase == 3) ? ((phase == 3) ? 37 : 53) : 0;
      recv_stall_pct = (phase == 2 || phase == 3) ? ((phase == 3) ? 37 : 53) : 0;
      for (i = 0; i < 330; i++) send_random();
    end
    req_valid <= 1'b0;
    waited = 0;
    while (board.pending.size() != 0 && waited < 200000) begin
      @(posedge clk);
      waited++;
    end
    repeat (700) @(posedge clk);
    $display("Sent %0d requests, checked %0d results (%0d exact, %0d zero divisor).",
             requests_sent, board.checked, board.exact_seen, board.error_seen);
    if (board.mismatches == 0 && board.pending.size() == 0)
      $display("tb_resample_ratio_cfrac_approx: PASS");
    else
      $display("tb_resample_ratio_cfrac_approx: FAIL");
    $finish;
  end
endmodule

### files.f
hw/rtl/rrca_pkg.sv
hw/rtl/rrca_div.sv
hw/rtl/rrca_norm.sv
hw/rtl/resample_ratio_cfrac_approx.sv
verif/tb_resample_ratio_cfrac_approx.sv
